// File: src/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, constants and register codes of the pan/tilt tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int FRAME_WIDTH  = 640;
   localparam int FRAME_HEIGHT = 480;

   localparam int ANGLE_W = 8;
   localparam int TIME_W  = 32;
   localparam int CAM_W   = 16;

   // reciprocal scaling: q = (pos * |hi - lo| * RECIP) >> SHIFT
   localparam int PAN_POS_W     = $clog2(FRAME_WIDTH + 1);
   localparam int PAN_SHIFT     = $clog2(64'd256 * FRAME_WIDTH * FRAME_WIDTH);
   localparam longint PAN_RECIP = ((64'd1 << PAN_SHIFT) + FRAME_WIDTH - 1) / FRAME_WIDTH;
   localparam int PAN_RECIP_W   = $clog2(PAN_RECIP + 1);
   localparam int PAN_SCALE_W   = PAN_RECIP_W + ANGLE_W;
   localparam int PAN_PROD_W    = PAN_POS_W + PAN_SCALE_W;

   localparam int TILT_POS_W     = $clog2(FRAME_HEIGHT + 1);
   localparam int TILT_SHIFT     = $clog2(64'd256 * FRAME_HEIGHT * FRAME_HEIGHT);
   localparam longint TILT_RECIP = ((64'd1 << TILT_SHIFT) + FRAME_HEIGHT - 1) / FRAME_HEIGHT;
   localparam int TILT_RECIP_W   = $clog2(TILT_RECIP + 1);
   localparam int TILT_SCALE_W   = TILT_RECIP_W + ANGLE_W;
   localparam int TILT_PROD_W    = TILT_POS_W + TILT_SCALE_W;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_PAN_MIN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAN_MAX  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELAY    = 3'd5;

   localparam logic [ANGLE_W-1:0] PAN_MIN_RST  = 8'd40;
   localparam logic [ANGLE_W-1:0] PAN_MAX_RST  = 8'd140;
   localparam logic [ANGLE_W-1:0] TILT_MIN_RST = 8'd50;
   localparam logic [ANGLE_W-1:0] TILT_MAX_RST = 8'd130;
   localparam logic [ANGLE_W-1:0] DEADBAND_RST = 8'd2;
   localparam logic [TIME_W-1:0]  DELAY_RST    = 32'd10000;
   localparam logic [ANGLE_W-1:0] HELD_RST     = 8'd90;

   localparam logic [PAN_SCALE_W-1:0] PAN_SCALE_RST =
      PAN_SCALE_W'((PAN_MAX_RST - PAN_MIN_RST) * PAN_RECIP);
   localparam logic [TILT_SCALE_W-1:0] TILT_SCALE_RST =
      TILT_SCALE_W'((TILT_MAX_RST - TILT_MIN_RST) * TILT_RECIP);

   localparam logic FUNC_REPORT = 1'b0;
   localparam logic FUNC_POLL   = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [TIME_W-1:0]        now_ms;
      logic                     face_present;
      logic signed [CAM_W-1:0]  cam_x;
      logic signed [CAM_W-1:0]  cam_y;
   } item_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]       pan_lo;
      logic                     pan_neg;
      logic [PAN_SCALE_W-1:0]   pan_scale;
      logic [ANGLE_W-1:0]       tilt_lo;
      logic                     tilt_neg;
      logic [TILT_SCALE_W-1:0]  tilt_scale;
      logic [ANGLE_W-1:0]       deadband;
      logic [TIME_W-1:0]        absence_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] pan;
      logic [ANGLE_W-1:0] tilt;
   } target_type;

   typedef struct packed {
      logic               pan_write;
      logic [ANGLE_W-1:0] pan_angle;
      logic               tilt_write;
      logic [ANGLE_W-1:0] tilt_angle;
      logic               happy_event;
      logic               sad_event;
   } result_type;

endpackage

// File: src/pan_tilt_tracker_with_presence.sv
// ----------------------------------------------------------------------------
// pan_tilt_tracker_with_presence
// Face tracker: maps face position to pan/tilt servo angles with a deadband
// and raises happy/sad events on face return and long absence.
//
//   channel | direction | handshake       | word
//   req     | in        | valid / stall   | func, now_ms, face_present, cam_x/y
//   rsp     | out       | valid / stall   | pan/tilt write and angle, events
//   csr     | in        | write_en        | index, wdata (no read-back)
//
// One word per cycle sustained while rsp_stall is low; after its request is
// taken, a response word passes the input register, then the result register.
// The per-word path is the position-by-scale multiply in ptt_map followed by
// the deadband compare in ptt_track.
// Reset is synchronous; all but the input and result data registers reset.
// rsp_stall holds the result register, which in turn holds the input
// register and raises req_stall only when both are full.
// ----------------------------------------------------------------------------
module pan_tilt_tracker_with_presence
   import ptt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_func,
   input  logic [TIME_W-1:0]       req_now_ms,
   input  logic                    req_face_present,
   input  logic signed [CAM_W-1:0] req_cam_x,
   input  logic signed [CAM_W-1:0] req_cam_y,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_pan_write,
   output logic [ANGLE_W-1:0]      rsp_pan_angle,
   output logic                    rsp_tilt_write,
   output logic [ANGLE_W-1:0]      rsp_tilt_angle,
   output logic                    rsp_happy_event,
   output logic                    rsp_sad_event,

   input  logic                    csr_write_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   item_type   item_ff, item_in;
   logic       req_accept, advance;
   cfg_type    cfg;
   target_type target;
   result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_in.func         = req_func;
      item_in.now_ms       = req_now_ms;
      item_in.face_present = req_face_present;
      item_in.cam_x        = req_cam_x;
      item_in.cam_y        = req_cam_y;

      priority if (req_accept)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      priority if (advance)
         out_valid_in = 1'b1;
      else if (!rsp_stall)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
   end

   ptt_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   ptt_map u_map (
      .item   (item_ff),
      .cfg    (cfg),
      .target (target)
   );

   ptt_track u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .target  (target),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_pan_write   = result.pan_write;
   assign rsp_pan_angle   = result.pan_angle;
   assign rsp_tilt_write  = result.tilt_write;
   assign rsp_tilt_angle  = result.tilt_angle;
   assign rsp_happy_event = result.happy_event;
   assign rsp_sad_event   = result.sad_event;

   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_happy_event && rsp_sad_event))
      else $error("happy and sad event in one word");

   a_sad_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sad_event |-> !rsp_pan_write && !rsp_tilt_write)
      else $error("axis written on a poll");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("blocked input word lost or changed");

   a_output_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(result))
      else $error("stalled result lost or changed");

endmodule

// File: src/ptt_csr.sv
// ----------------------------------------------------------------------------
// ptt_csr
// Configuration registers and the per-axis scale factors derived from them.
// ----------------------------------------------------------------------------
module ptt_csr
   import ptt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   logic [ANGLE_W-1:0]      pan_min_ff, pan_max_ff, tilt_min_ff, tilt_max_ff;
   logic [ANGLE_W-1:0]      deadband_ff;
   logic [TIME_W-1:0]       delay_ff;
   logic [PAN_SCALE_W-1:0]  pan_scale_ff, pan_scale_in;
   logic [TILT_SCALE_W-1:0] tilt_scale_ff, tilt_scale_in;
   logic                    pan_neg_ff, pan_neg_in, tilt_neg_ff, tilt_neg_in;
   logic [ANGLE_W:0]        pan_diff, tilt_diff;
   logic [ANGLE_W-1:0]      pan_mag, tilt_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_min_ff  <= PAN_MIN_RST;
         pan_max_ff  <= PAN_MAX_RST;
         tilt_min_ff <= TILT_MIN_RST;
         tilt_max_ff <= TILT_MAX_RST;
         deadband_ff <= DEADBAND_RST;
         delay_ff    <= DELAY_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PAN_MIN:  pan_min_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_PAN_MAX:  pan_max_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_TILT_MIN: tilt_min_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_TILT_MAX: tilt_max_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_DEADBAND: deadband_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_DELAY:    delay_ff    <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // span direction and magnitude, then scale by the frame reciprocal
   always_comb begin
      pan_diff      = {1'b0, pan_max_ff} - {1'b0, pan_min_ff};
      tilt_diff     = {1'b0, tilt_max_ff} - {1'b0, tilt_min_ff};
      pan_neg_in    = pan_diff[ANGLE_W];
      tilt_neg_in   = tilt_diff[ANGLE_W];
      pan_mag       = pan_neg_in ? ANGLE_W'(~pan_diff + 1'b1) : pan_diff[ANGLE_W-1:0];
      tilt_mag      = tilt_neg_in ? ANGLE_W'(~tilt_diff + 1'b1) : tilt_diff[ANGLE_W-1:0];
      pan_scale_in  = PAN_SCALE_W'(pan_mag) * PAN_SCALE_W'(PAN_RECIP);
      tilt_scale_in = TILT_SCALE_W'(tilt_mag) * TILT_SCALE_W'(TILT_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pan_scale_ff  <= PAN_SCALE_RST;
         tilt_scale_ff <= TILT_SCALE_RST;
         pan_neg_ff    <= 1'b0;
         tilt_neg_ff   <= 1'b0;
      end else begin
         pan_scale_ff  <= pan_scale_in;
         tilt_scale_ff <= tilt_scale_in;
         pan_neg_ff    <= pan_neg_in;
         tilt_neg_ff   <= tilt_neg_in;
      end
   end

   assign cfg.pan_lo           = pan_min_ff;
   assign cfg.pan_neg          = pan_neg_ff;
   assign cfg.pan_scale        = pan_scale_ff;
   assign cfg.tilt_lo          = tilt_min_ff;
   assign cfg.tilt_neg         = tilt_neg_ff;
   assign cfg.tilt_scale       = tilt_scale_ff;
   assign cfg.deadband         = deadband_ff;
   assign cfg.absence_delay_ms = delay_ff;

endmodule

// File: src/ptt_map.sv
// ----------------------------------------------------------------------------
// ptt_map
// Clamp the face position to the frame and map it onto both angle ranges.
// ----------------------------------------------------------------------------
module ptt_map
   import ptt_pkg::*;
(
   input  item_type   item,
   input  cfg_type    cfg,
   output target_type target
);

   logic [PAN_POS_W-1:0]   pan_pos;
   logic [TILT_POS_W-1:0]  tilt_pos;
   logic [PAN_PROD_W-1:0]  pan_prod, pan_quo_full;
   logic [TILT_PROD_W-1:0] tilt_prod, tilt_quo_full;
   logic [ANGLE_W-1:0]     pan_quo, tilt_quo;

   always_comb begin
      priority if (item.cam_x[CAM_W-1])
         pan_pos = '0;
      else if ($unsigned(item.cam_x) > CAM_W'(FRAME_WIDTH))
         pan_pos = PAN_POS_W'(FRAME_WIDTH);
      else
         pan_pos = item.cam_x[PAN_POS_W-1:0];

      priority if (item.cam_y[CAM_W-1])
         tilt_pos = '0;
      else if ($unsigned(item.cam_y) > CAM_W'(FRAME_HEIGHT))
         tilt_pos = TILT_POS_W'(FRAME_HEIGHT);
      else
         tilt_pos = item.cam_y[TILT_POS_W-1:0];

      pan_prod      = PAN_PROD_W'(pan_pos) * PAN_PROD_W'(cfg.pan_scale);
      tilt_prod     = TILT_PROD_W'(tilt_pos) * TILT_PROD_W'(cfg.tilt_scale);
      pan_quo_full  = pan_prod >> PAN_SHIFT;
      tilt_quo_full = tilt_prod >> TILT_SHIFT;
      pan_quo       = pan_quo_full[ANGLE_W-1:0];
      tilt_quo      = tilt_quo_full[ANGLE_W-1:0];

      target.pan  = cfg.pan_neg ? cfg.pan_lo - pan_quo : cfg.pan_lo + pan_quo;
      target.tilt = cfg.tilt_neg ? cfg.tilt_lo - tilt_quo : cfg.tilt_lo + tilt_quo;
   end

endmodule

// File: src/ptt_track.sv
// ----------------------------------------------------------------------------
// ptt_track
// Tracker state, deadband and presence events, and the result register.
// ----------------------------------------------------------------------------
module ptt_track
   import ptt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   input  target_type target,
   input  cfg_type    cfg,
   output result_type result
);

   logic [ANGLE_W-1:0] held_pan_ff, held_pan_in, held_tilt_ff, held_tilt_in;
   logic [TIME_W-1:0]  last_seen_ff, last_seen_in;
   logic               present_ff, present_in, ever_seen_ff, ever_seen_in;
   logic               sad_done_ff, sad_done_in;
   result_type         result_ff, result_in;
   logic [TIME_W-1:0]  elapsed;
   logic               timed_out;
   logic [ANGLE_W:0]   pan_diff, tilt_diff;
   logic [ANGLE_W-1:0] pan_dist, tilt_dist;
   logic               pan_move, tilt_move;

   always_comb begin
      elapsed   = item.now_ms - last_seen_ff;
      timed_out = elapsed >= cfg.absence_delay_ms;
      pan_diff  = {1'b0, target.pan} - {1'b0, held_pan_ff};
      tilt_diff = {1'b0, target.tilt} - {1'b0, held_tilt_ff};
      pan_dist  = pan_diff[ANGLE_W] ? ANGLE_W'(~pan_diff + 1'b1) : pan_diff[ANGLE_W-1:0];
      tilt_dist = tilt_diff[ANGLE_W] ? ANGLE_W'(~tilt_diff + 1'b1) : tilt_diff[ANGLE_W-1:0];
      pan_move  = pan_dist > cfg.deadband;
      tilt_move = tilt_dist > cfg.deadband;

      held_pan_in  = held_pan_ff;
      held_tilt_in = held_tilt_ff;
      last_seen_in = last_seen_ff;
      present_in   = present_ff;
      ever_seen_in = ever_seen_ff;
      sad_done_in  = sad_done_ff;
      result_in    = '0;

      priority if (item.func == FUNC_POLL) begin
         if (!present_ff && ever_seen_ff && !sad_done_ff && timed_out) begin
            result_in.sad_event = 1'b1;
            sad_done_in         = 1'b1;
         end
      end else if (item.face_present) begin
         result_in.happy_event = !present_ff && timed_out;
         present_in            = 1'b1;
         ever_seen_in          = 1'b1;
         sad_done_in           = 1'b0;
         last_seen_in          = item.now_ms;
         result_in.pan_write   = pan_move;
         result_in.tilt_write  = tilt_move;
         if (pan_move) begin
            held_pan_in = target.pan;
         end
         if (tilt_move) begin
            held_tilt_in = target.tilt;
         end
      end else begin
         present_in = 1'b0;
      end

      result_in.pan_angle  = held_pan_in;
      result_in.tilt_angle = held_tilt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_pan_ff  <= HELD_RST;
         held_tilt_ff <= HELD_RST;
         last_seen_ff <= '0;
         present_ff   <= 1'b0;
         ever_seen_ff <= 1'b0;
         sad_done_ff  <= 1'b0;
      end else if (advance) begin
         held_pan_ff  <= held_pan_in;
         held_tilt_ff <= held_tilt_in;
         last_seen_ff <= last_seen_in;
         present_ff   <= present_in;
         ever_seen_ff <= ever_seen_in;
         sad_done_ff  <= sad_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: test/tb_pan_tilt_tracker_with_presence.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pan_tilt_tracker_with_presence
// Self-checking bench for the pan/tilt tracker. Every request word accepted
// is run through a software copy of the servo mapping, deadband and presence
// logic, and the predicted command is queued. Every response word accepted
// is compared field by field with the oldest queued command. A directed part
// covers the frame edges, the deadband edge, and happy and sad events. Random
// phases then run under several register settings and handshake pressures.
// ----------------------------------------------------------------------------
import ptt_pkg::*;

class tracker_checker;
   bit [ANGLE_W-1:0] pan_lo, pan_hi, tilt_lo, tilt_hi, deadband;
   bit [TIME_W-1:0]  delay_ms;
   bit [ANGLE_W-1:0] held_pan, held_tilt;
   bit [TIME_W-1:0]  last_seen;
   bit               present, ever_seen, sad_done;
   result_type       cmds_due[$];
   int               bad_words;

   function new();
      pan_lo    = PAN_MIN_RST;
      pan_hi    = PAN_MAX_RST;
      tilt_lo   = TILT_MIN_RST;
      tilt_hi   = TILT_MAX_RST;
      deadband  = DEADBAND_RST;
      delay_ms  = DELAY_RST;
      held_pan  = HELD_RST;
      held_tilt = HELD_RST;
      last_seen = '0;
      present   = 1'b0;
      ever_seen = 1'b0;
      sad_done  = 1'b0;
      bad_words = 0;
   endfunction

   function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_PAN_MIN:  pan_lo   = data[ANGLE_W-1:0];
         CSR_PAN_MAX:  pan_hi   = data[ANGLE_W-1:0];
         CSR_TILT_MIN: tilt_lo  = data[ANGLE_W-1:0];
         CSR_TILT_MAX: tilt_hi  = data[ANGLE_W-1:0];
         CSR_DEADBAND: deadband = data[ANGLE_W-1:0];
         CSR_DELAY:    delay_ms = data[TIME_W-1:0];
         default: ;
      endcase
   endfunction

   function bit [ANGLE_W-1:0] map_angle(int pos, int span, bit [ANGLE_W-1:0] lo,
                                        bit [ANGLE_W-1:0] hi);
      longint p;
      longint q;
      p = pos;
      if (p < 0) p = 0;
      if (p > span) p = span;
      q = (p * (longint'(hi) - longint'(lo))) / longint'(span) + longint'(lo);
      return q[ANGLE_W-1:0];
   endfunction

   function bit steer(inout bit [ANGLE_W-1:0] held, input bit [ANGLE_W-1:0] target);
      int d;
      d = int'(target) - int'(held);
      if (d < 0) d = -d;
      if (d > int'(deadband)) begin
         held = target;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void take_word(item_type w);
      result_type       r;
      bit [TIME_W-1:0]  elapsed;
      r = '0;
      elapsed = w.now_ms - last_seen;
      if (w.func == FUNC_POLL) begin
         if (!present && ever_seen && !sad_done && elapsed >= delay_ms) begin
            r.sad_event = 1'b1;
            sad_done = 1'b1;
         end
      end else if (w.face_present) begin
         if (!present && elapsed >= delay_ms) r.happy_event = 1'b1;
         present   = 1'b1;
         ever_seen = 1'b1;
         sad_done  = 1'b0;
         last_seen = w.now_ms;
         r.pan_write  = steer(held_pan,
                              map_angle(int'(w.cam_x), FRAME_WIDTH, pan_lo, pan_hi));
         r.tilt_write = steer(held_tilt,
                              map_angle(int'(w.cam_y), FRAME_HEIGHT, tilt_lo, tilt_hi));
      end else begin
         present = 1'b0;
      end
      r.pan_angle  = held_pan;
      r.tilt_angle = held_tilt;
      cmds_due.push_back(r);
   endfunction

   function void check_word(result_type got);
      result_type want;
      if (cmds_due.size() == 0) begin
         bad_words++;
         if (bad_words <= 10) $display("%0t: response word with no command pending", $time);
         return;
      end
      want = cmds_due.pop_front();
      if (got.pan_write !== want.pan_write || got.pan_angle !== want.pan_angle ||
          got.tilt_write !== want.tilt_write || got.tilt_angle !== want.tilt_angle ||
          got.happy_event !== want.happy_event || got.sad_event !== want.sad_event) begin
         bad_words++;
         if (bad_words <= 10) begin
            $display("%0t: mismatch expected pw=%0d pan=%0d tw=%0d tilt=%0d happy=%0d sad=%0d",
                     $time, want.pan_write, want.pan_angle, want.tilt_write,
                     want.tilt_angle, want.happy_event, want.sad_event);
            $display("%0t:          actual   pw=%0d pan=%0d tw=%0d tilt=%0d happy=%0d sad=%0d",
                     $time, got.pan_write, got.pan_angle, got.tilt_write,
                     got.tilt_angle, got.happy_event, got.sad_event);
         end
      end
   endfunction
endclass

module tb_pan_tilt_tracker_with_presence;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int WORDS_PER_PHASE = 220;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_func = FUNC_REPORT;
   logic [TIME_W-1:0]       req_now_ms = '0;
   logic                    req_face_present = 1'b0;
   logic signed [CAM_W-1:0] req_cam_x = '0;
   logic signed [CAM_W-1:0] req_cam_y = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_pan_write;
   logic [ANGLE_W-1:0]      rsp_pan_angle;
   logic                    rsp_tilt_write;
   logic [ANGLE_W-1:0]      rsp_tilt_angle;
   logic                    rsp_happy_event;
   logic                    rsp_sad_event;

   logic                    csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   tracker_checker   servo_check;
   int               sender_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_req = 0;
   int               hold_left = 0;
   bit [TIME_W-1:0]  clock_ms = '0;
   bit               face_on = 1'b0;
   int               last_x = 320;
   int               last_y = 240;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   pan_tilt_tracker_with_presence u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_now_ms       (req_now_ms),
      .req_face_present (req_face_present),
      .req_cam_x        (req_cam_x),
      .req_cam_y        (req_cam_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pan_write    (rsp_pan_write),
      .rsp_pan_angle    (rsp_pan_angle),
      .rsp_tilt_write   (rsp_tilt_write),
      .rsp_tilt_angle   (rsp_tilt_angle),
      .rsp_happy_event  (rsp_happy_event),
      .rsp_sad_event    (rsp_sad_event),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // hold off for a long stretch on request, else stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req > 0) begin
         hold_left <= hold_req;
         hold_req = 0;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.pan_write   = rsp_pan_write;
         got.pan_angle   = rsp_pan_angle;
         got.tilt_write  = rsp_tilt_write;
         got.tilt_angle  = rsp_tilt_angle;
         got.happy_event = rsp_happy_event;
         got.sad_event   = rsp_sad_event;
         servo_check.check_word(got);
      end
   end

   task automatic send_word(input item_type w);
      req_valid        <= 1'b1;
      req_func         <= w.func;
      req_now_ms       <= w.now_ms;
      req_face_present <= w.face_present;
      req_cam_x        <= w.cam_x;
      req_cam_y        <= w.cam_y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      servo_check.take_word(w);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_fields(input logic f, input logic [TIME_W-1:0] t, input logic p,
                              input int x, input int y);
      item_type w;
      w.func         = f;
      w.now_ms       = t;
      w.face_present = p;
      w.cam_x        = CAM_W'(x);
      w.cam_y        = CAM_W'(y);
      send_word(w);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      servo_check.set_register(index, data);
   endtask

   // drop valid, then wait out every pending command and the pipeline
   task automatic settle();
      req_valid <= 1'b0;
      while (servo_check.cmds_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] with_junk_top(input bit [ANGLE_W-1:0] v);
      return {$urandom() & 32'hFFFF_FF00} | CSR_DATA_W'(v);
   endfunction

   function automatic item_type random_word();
      item_type w;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 45)
         clock_ms += $urandom_range(0, 50);
      else if (pick < 65)
         clock_ms = servo_check.last_seen + servo_check.delay_ms - 1 + $urandom_range(0, 2);
      else if (pick < 75)
         clock_ms = servo_check.last_seen + servo_check.delay_ms + $urandom_range(0, 1000);
      else if (pick < 88)
         clock_ms += $urandom();
      else
         clock_ms -= $urandom_range(0, 100);
      if ($urandom_range(99) < 12) face_on = !face_on;
      w.func         = ($urandom_range(99) < 30) ? FUNC_POLL : FUNC_REPORT;
      w.now_ms       = clock_ms;
      w.face_present = face_on ^ ($urandom_range(99) < 5);
      pick = $urandom_range(99);
      if (pick < 60) begin
         last_x = int'($urandom_range(0, 700)) - 30;
         last_y = int'($urandom_range(0, 540)) - 30;
      end else if (pick < 85) begin
         last_x = last_x + int'($urandom_range(0, 10)) - 5;
         last_y = last_y + int'($urandom_range(0, 10)) - 5;
      end else begin
         w.cam_x = CAM_W'($urandom());
         w.cam_y = CAM_W'($urandom());
         last_x = int'(w.cam_x);
         last_y = int'(w.cam_y);
      end
      w.cam_x = CAM_W'(last_x);
      w.cam_y = CAM_W'(last_y);
      return w;
   endfunction

   initial begin
      bit [ANGLE_W-1:0] a_pl, a_ph, a_tl, a_th, a_db;
      bit [TIME_W-1:0]  a_dl;
      servo_check = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_fields(FUNC_POLL,   32'd0,     1'b1, 0, 0);
      send_fields(FUNC_REPORT, 32'd1,     1'b0, 320, 240);
      send_fields(FUNC_REPORT, 32'd10000, 1'b1, 0, 0);
      send_fields(FUNC_REPORT, 32'd10001, 1'b1, 640, 480);
      send_fields(FUNC_REPORT, 32'd10002, 1'b1, 32767, 32767);
      send_fields(FUNC_REPORT, 32'd10003, 1'b1, -32768, -32768);
      send_fields(FUNC_REPORT, 32'd10004, 1'b1, -1, 481);
      send_fields(FUNC_REPORT, 32'd10005, 1'b1, 13, 12);
      send_fields(FUNC_REPORT, 32'd10006, 1'b1, 20, 18);
      send_fields(FUNC_POLL,   32'd30000, 1'b0, 0, 0);
      send_fields(FUNC_REPORT, 32'd10008, 1'b0, 16'h5555, 16'hAAAA);
      send_fields(FUNC_POLL,   32'd20005, 1'b1, 0, 0);
      send_fields(FUNC_POLL,   32'd20006, 1'b0, 0, 0);
      send_fields(FUNC_POLL,   32'd20007, 1'b0, 0, 0);
      send_fields(FUNC_REPORT, 32'd20009, 1'b1, 16'h5555, 16'h2AAA);
      send_fields(FUNC_REPORT, 32'd20010, 1'b0, 100, 100);
      send_fields(FUNC_REPORT, 32'd20011, 1'b1, 600, 30);
      send_fields(FUNC_REPORT, 32'hFFFF_FFF0, 1'b0, 0, 0);
      send_fields(FUNC_POLL,   32'hFFFF_FFFF, 1'b0, 0, 0);
      send_fields(FUNC_REPORT, 32'd5,     1'b1, 16'h7FFF, 16'h8000);
      send_fields(FUNC_REPORT, 32'h5555_5555, 1'b1, 16'hAAAA, 16'h5555);
      send_fields(FUNC_REPORT, 32'hAAAA_AAAA, 1'b1, 160, 120);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase > 0) begin
            settle();
            case (phase)
               1: begin
                  a_pl = 0;   a_ph = 180; a_tl = 0;   a_th = 180;
                  a_db = 0;   a_dl = '0;
               end
               2: begin
                  a_pl = 180; a_ph = 0;   a_tl = 180; a_th = 0;
                  a_db = 180; a_dl = 32'hFFFF_FFFF;
               end
               3: begin
                  a_pl = 90;  a_ph = 90;  a_tl = 180; a_th = 0;
                  a_db = 1;   a_dl = 32'd1;
               end
               default: begin
                  a_pl = ANGLE_W'($urandom_range(0, 180));
                  a_ph = ANGLE_W'($urandom_range(0, 180));
                  a_tl = ANGLE_W'($urandom_range(0, 180));
                  a_th = ANGLE_W'($urandom_range(0, 180));
                  a_db = ($urandom_range(99) < 80) ? ANGLE_W'($urandom_range(0, 8))
                                                   : ANGLE_W'($urandom_range(0, 180));
                  case ($urandom_range(2))
                     0: a_dl = $urandom_range(0, 200);
                     1: a_dl = $urandom_range(1000, 30000);
                     default: a_dl = $urandom();
                  endcase
               end
            endcase
            write_reg(CSR_PAN_MIN,  with_junk_top(a_pl));
            write_reg(CSR_PAN_MAX,  with_junk_top(a_ph));
            write_reg(CSR_TILT_MIN, with_junk_top(a_tl));
            write_reg(CSR_TILT_MAX, with_junk_top(a_th));
            write_reg(CSR_DEADBAND, with_junk_top(a_db));
            write_reg(CSR_DELAY,    a_dl);
            write_reg(CSR_SPARE_A,  $urandom());
            write_reg(CSR_SPARE_B,  $urandom());
            csr_write_en <= 1'b0;
            @(posedge clock);
         end
         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         if (phase % 4 == 0) hold_req = 60;
         repeat (WORDS_PER_PHASE) send_word(random_word());
      end

      settle();
      if (servo_check.bad_words == 0 && servo_check.cmds_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
